### src/quadratic_root_solver_unit_defines.svh
// Assertion macros used by the quadratic root solver top level.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QRS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quadratic root solver check failed");

// Next-cycle implication, disabled while reset is high.
`define QRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quadratic root solver check failed");

`endif

### src/qrs_pkg.sv
// Shared types, constants and helper functions of the quadratic root solver.
`default_nettype none
package qrs_pkg;

   localparam int COEF_W     = 32;
   localparam int TOL_W      = 16;
   localparam int DTOL_W     = 32;
   localparam int DISC_W     = 68;
   localparam int SQ_IN_W    = 66;
   localparam int SQ_STEPS   = 33;
   localparam int SQ_OUT_W   = 33;
   localparam int NUM_MAG_W  = 35;
   localparam int FRAC_W     = 16;
   localparam int DIV_N_W    = NUM_MAG_W + FRAC_W;
   localparam int DIV_D_W    = 33;

   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;
   localparam logic [1:0] COUNT_INF  = 2'd3;

   localparam logic CSR_COEF_TOL = 1'b0;
   localparam logic CSR_DISC_TOL = 1'b1;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_INF,
      KIND_LIN,
      KIND_ONE,
      KIND_TWO
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [COEF_W-1:0]  a;
      logic signed [COEF_W-1:0]  b;
      logic signed [COEF_W-1:0]  c;
   } side_type;

   typedef struct packed {
      kind_type kind;
      logic     neg0;
      logic     neg1;
   } div_side_type;

   function automatic logic near_zero(input logic signed [COEF_W-1:0] v,
                                      input logic [TOL_W-1:0] tol);
      logic [COEF_W:0] m;
      m = v[COEF_W-1] ? ((COEF_W+1)'(0) - {1'b1, v}) : {1'b0, v};
      return m <= (COEF_W+1)'(tol);
   endfunction

endpackage
`default_nettype wire

### src/qrs_front.sv
// Front stages: coefficient classification, products and discriminant.
`default_nettype none
module qrs_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic                              in_valid,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] in_a,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] in_b,
   input  wire logic signed [qrs_pkg::COEF_W-1:0] in_c,
   input  wire logic [qrs_pkg::TOL_W-1:0]         coef_tol,
   input  wire logic [qrs_pkg::DTOL_W-1:0]        disc_tol,
   output logic                                   out_valid,
   output logic [qrs_pkg::SQ_IN_W-1:0]            out_x,
   output qrs_pkg::side_type                      out_side
);

   // Stage one: products and near-zero flags.
   logic                              v1_ff;
   logic signed [qrs_pkg::COEF_W-1:0] a1_ff, b1_ff, c1_ff;
   logic signed [63:0]                bb1_ff, ac1_ff, bb1_in, ac1_in;
   logic                              na1_ff, nb1_ff, nc1_ff;

   // Stage two: exact discriminant.
   logic                              v2_ff;
   logic signed [qrs_pkg::COEF_W-1:0] a2_ff, b2_ff, c2_ff;
   logic                              na2_ff, nb2_ff, nc2_ff;
   logic signed [qrs_pkg::DISC_W-1:0] d2_ff, d2_in;

   // Stage three: classification.
   logic                              v3_ff;
   logic [qrs_pkg::SQ_IN_W-1:0]       x3_ff, x3_in;
   qrs_pkg::side_type                 s3_ff, s3_in;
   logic [qrs_pkg::DISC_W-1:0]        dmag;
   logic                              disc_small;

   assign bb1_in = in_b * in_b;
   assign ac1_in = in_a * in_c;
   assign d2_in  = qrs_pkg::DISC_W'(bb1_ff) - (qrs_pkg::DISC_W'(ac1_ff) <<< 2);

   always_comb begin
      dmag   = d2_ff[qrs_pkg::DISC_W-1] ? qrs_pkg::DISC_W'(-d2_ff) : qrs_pkg::DISC_W'(d2_ff);
      disc_small = dmag <= qrs_pkg::DISC_W'(disc_tol);
      s3_in.a = a2_ff;
      s3_in.b = b2_ff;
      s3_in.c = c2_ff;
      x3_in   = '0;
      if (na2_ff) begin
         if (nb2_ff) begin
            s3_in.kind = nc2_ff ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
         end else begin
            s3_in.kind = qrs_pkg::KIND_LIN;
         end
      end else if (disc_small) begin
         s3_in.kind = qrs_pkg::KIND_ONE;
      end else if (d2_ff[qrs_pkg::DISC_W-1]) begin
         s3_in.kind = qrs_pkg::KIND_NONE;
      end else begin
         s3_in.kind = qrs_pkg::KIND_TWO;
         x3_in      = d2_ff[qrs_pkg::SQ_IN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (advance) begin
         a1_ff  <= in_a;
         b1_ff  <= in_b;
         c1_ff  <= in_c;
         bb1_ff <= bb1_in;
         ac1_ff <= ac1_in;
         na1_ff <= qrs_pkg::near_zero(in_a, coef_tol);
         nb1_ff <= qrs_pkg::near_zero(in_b, coef_tol);
         nc1_ff <= qrs_pkg::near_zero(in_c, coef_tol);
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         c2_ff  <= c1_ff;
         na2_ff <= na1_ff;
         nb2_ff <= nb1_ff;
         nc2_ff <= nc1_ff;
         d2_ff  <= d2_in;
         x3_ff  <= x3_in;
         s3_ff  <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_x     = x3_ff;
   assign out_side  = s3_ff;

endmodule
`default_nettype wire

### src/qrs_sqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module qrs_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [qrs_pkg::SQ_IN_W-1:0]   in_x,
   input  wire qrs_pkg::side_type             in_side,
   output logic                               out_valid,
   output logic [qrs_pkg::SQ_OUT_W-1:0]       out_root,
   output qrs_pkg::side_type                  out_side
);

   localparam int STEPS = qrs_pkg::SQ_STEPS;
   localparam int W     = qrs_pkg::SQ_IN_W;

   logic [W-1:0]      x_ff [STEPS];
   logic [W-1:0]      r_ff [STEPS];
   logic              v_ff [STEPS];
   qrs_pkg::side_type s_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [W:0] BIT = (W+1)'(1) << (2 * (STEPS - 1 - k));
      logic [W-1:0]      x_src, r_src, x_in, r_in;
      logic              v_src;
      qrs_pkg::side_type s_src;
      logic [W:0]        trial;

      if (k == 0) begin : g_first
         assign x_src = in_x;
         assign r_src = '0;
         assign v_src = in_valid;
         assign s_src = in_side;
      end else begin : g_rest
         assign x_src = x_ff[k-1];
         assign r_src = r_ff[k-1];
         assign v_src = v_ff[k-1];
         assign s_src = s_ff[k-1];
      end

      always_comb begin
         trial = {1'b0, r_src} + BIT;
         if ({1'b0, x_src} >= trial) begin
            x_in = W'({1'b0, x_src} - trial);
            r_in = W'({1'b0, r_src >> 1} + BIT);
         end else begin
            x_in = x_src;
            r_in = r_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_src;
         end
         if (advance) begin
            x_ff[k] <= x_in;
            r_ff[k] <= r_in;
            s_ff[k] <= s_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_root  = r_ff[STEPS-1][qrs_pkg::SQ_OUT_W-1:0];
   assign out_side  = s_ff[STEPS-1];

endmodule
`default_nettype wire

### src/qrs_div.sv
// Pipelined two-lane restoring divider over magnitudes, one quotient bit per stage.
`default_nettype none
module qrs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [qrs_pkg::DIV_N_W-1:0]   in_num0,
   input  wire logic [qrs_pkg::DIV_N_W-1:0]   in_num1,
   input  wire logic [qrs_pkg::DIV_D_W-1:0]   in_den,
   input  wire qrs_pkg::div_side_type         in_side,
   output logic                               out_valid,
   output logic [qrs_pkg::DIV_N_W-1:0]        out_quot0,
   output logic [qrs_pkg::DIV_N_W-1:0]        out_quot1,
   output qrs_pkg::div_side_type              out_side
);

   localparam int STEPS = qrs_pkg::DIV_N_W;
   localparam int DW    = qrs_pkg::DIV_D_W;

   // Each numerator register shifts dividend bits out at the top and
   // quotient bits in at the bottom.
   logic [STEPS-1:0]          nq0_ff [STEPS];
   logic [STEPS-1:0]          nq1_ff [STEPS];
   logic [DW-1:0]             rem0_ff [STEPS];
   logic [DW-1:0]             rem1_ff [STEPS];
   logic [DW-1:0]             den_ff [STEPS];
   logic                      v_ff [STEPS];
   qrs_pkg::div_side_type     s_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [STEPS-1:0]      nq0_src, nq1_src, nq0_in, nq1_in;
      logic [DW-1:0]         rem0_src, rem1_src, rem0_in, rem1_in, den_src;
      logic                  v_src, ge0, ge1;
      qrs_pkg::div_side_type s_src;
      logic [DW:0]           rw0, rw1;

      if (k == 0) begin : g_first
         assign nq0_src  = in_num0;
         assign nq1_src  = in_num1;
         assign rem0_src = '0;
         assign rem1_src = '0;
         assign den_src  = in_den;
         assign v_src    = in_valid;
         assign s_src    = in_side;
      end else begin : g_rest
         assign nq0_src  = nq0_ff[k-1];
         assign nq1_src  = nq1_ff[k-1];
         assign rem0_src = rem0_ff[k-1];
         assign rem1_src = rem1_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign v_src    = v_ff[k-1];
         assign s_src    = s_ff[k-1];
      end

      always_comb begin
         rw0     = {rem0_src, nq0_src[STEPS-1]};
         rw1     = {rem1_src, nq1_src[STEPS-1]};
         ge0     = rw0 >= {1'b0, den_src};
         ge1     = rw1 >= {1'b0, den_src};
         rem0_in = ge0 ? DW'(rw0 - {1'b0, den_src}) : rw0[DW-1:0];
         rem1_in = ge1 ? DW'(rw1 - {1'b0, den_src}) : rw1[DW-1:0];
         nq0_in  = {nq0_src[STEPS-2:0], ge0};
         nq1_in  = {nq1_src[STEPS-2:0], ge1};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= v_src;
         end
         if (advance) begin
            nq0_ff[k]  <= nq0_in;
            nq1_ff[k]  <= nq1_in;
            rem0_ff[k] <= rem0_in;
            rem1_ff[k] <= rem1_in;
            den_ff[k]  <= den_src;
            s_ff[k]    <= s_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_quot0 = nq0_ff[STEPS-1];
   assign out_quot1 = nq1_ff[STEPS-1];
   assign out_side  = s_ff[STEPS-1];

endmodule
`default_nettype wire

### src/quadratic_root_solver_unit.sv
// Top level of the pipelined quadratic root solver.
// Pipeline from an accepted req beat to its rsp beat: front, root, prep, divide and output stages, in that order.
// Throughput: one coefficient beat per cycle while rsp_tready is high; the whole pipeline holds when the output beat is stalled.
// Reset: synchronous, active high; clears every valid bit and sets both tolerances to 1.
// Configuration writes are always accepted (csr_ready is tied high) and take effect on the next cycle.
`default_nettype none
`include "quadratic_root_solver_unit_defines.svh"
module quadratic_root_solver_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: coef_a [31:0], coef_b [63:32], coef_c [95:64].
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,
   // rsp_tdata: root_count [1:0], first_root [33:2], second_root [65:34],
   // overflow [66], zero padding [71:67].
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   // The whole pipeline moves in lockstep. It advances whenever the output
   // register is empty or its beat is being taken this cycle, so no stage
   // is ever overwritten or duplicated during a stall.
   logic advance;

   logic [qrs_pkg::TOL_W-1:0]  coef_tol_ff;
   logic [qrs_pkg::DTOL_W-1:0] disc_tol_ff;

   logic                            fr_valid;
   logic [qrs_pkg::SQ_IN_W-1:0]     fr_x;
   qrs_pkg::side_type               fr_side;

   logic                            sq_valid;
   logic [qrs_pkg::SQ_OUT_W-1:0]    sq_root;
   qrs_pkg::side_type               sq_side;

   // Preparation stage: signed numerators and denominator are turned into
   // magnitudes with a sign per lane, and the fraction bits are appended.
   logic                            pv_ff;
   logic [qrs_pkg::DIV_N_W-1:0]     pn0_ff, pn1_ff, pn0_in, pn1_in;
   logic [qrs_pkg::DIV_D_W-1:0]     pd_ff, pd_in;
   qrs_pkg::div_side_type           ps_ff, ps_in;
   logic signed [35:0]              bx, sx, cx, n0, n1;
   logic signed [35:0]              m0, m1;
   logic signed [32:0]              dd, dm;

   logic                            dv_valid;
   logic [qrs_pkg::DIV_N_W-1:0]     dv_q0, dv_q1;
   qrs_pkg::div_side_type           dv_side;

   // Output register.
   logic                            rsp_valid_ff;
   logic [1:0]                      count_ff, count_in;
   logic [31:0]                     first_ff, first_in, second_ff, second_in;
   logic                            ovf_ff, ovf_in;
   logic [32:0]                     sat0, sat1;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_tol_ff <= qrs_pkg::TOL_W'(1);
         disc_tol_ff <= qrs_pkg::DTOL_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            qrs_pkg::CSR_COEF_TOL: coef_tol_ff <= csr_data[qrs_pkg::TOL_W-1:0];
            qrs_pkg::CSR_DISC_TOL: disc_tol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_a      (req_tdata[31:0]),
      .in_b      (req_tdata[63:32]),
      .in_c      (req_tdata[95:64]),
      .coef_tol  (coef_tol_ff),
      .disc_tol  (disc_tol_ff),
      .out_valid (fr_valid),
      .out_x     (fr_x),
      .out_side  (fr_side)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fr_valid),
      .in_x      (fr_x),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Lane 0 carries -c/b, -b/2a or -(b+s)/2a; lane 1 carries (s-b)/2a.
   always_comb begin
      bx = 36'(sq_side.b);
      cx = 36'(sq_side.c);
      sx = {3'b000, sq_root};
      n0 = '0;
      n1 = '0;
      dd = 33'sd1;
      case (sq_side.kind)
         qrs_pkg::KIND_LIN: begin
            n0 = -cx;
            dd = 33'(sq_side.b);
         end
         qrs_pkg::KIND_ONE: begin
            n0 = -bx;
            dd = {sq_side.a, 1'b0};
         end
         qrs_pkg::KIND_TWO: begin
            n0 = -(bx + sx);
            n1 = sx - bx;
            dd = {sq_side.a, 1'b0};
         end
         default: ;
      endcase
      m0         = n0[35] ? -n0 : n0;
      m1         = n1[35] ? -n1 : n1;
      dm         = dd[32] ? -dd : dd;
      pn0_in     = {m0[qrs_pkg::NUM_MAG_W-1:0], qrs_pkg::FRAC_W'(0)};
      pn1_in     = {m1[qrs_pkg::NUM_MAG_W-1:0], qrs_pkg::FRAC_W'(0)};
      pd_in      = dm;
      ps_in.kind = sq_side.kind;
      ps_in.neg0 = n0[35] ^ dd[32];
      ps_in.neg1 = n1[35] ^ dd[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (advance) begin
         pv_ff <= sq_valid;
      end
      if (advance) begin
         pn0_ff <= pn0_in;
         pn1_ff <= pn1_in;
         pd_ff  <= pd_in;
         ps_ff  <= ps_in;
      end
   end

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pv_ff),
      .in_num0   (pn0_ff),
      .in_num1   (pn1_ff),
      .in_den    (pd_ff),
      .in_side   (ps_ff),
      .out_valid (dv_valid),
      .out_quot0 (dv_q0),
      .out_quot1 (dv_q1),
      .out_side  (dv_side)
   );

   // Applies the sign to a quotient magnitude and saturates it to 32 bits.
   // Bit 32 of the result is the saturation flag.
   function automatic logic [32:0] sat_root(input logic [qrs_pkg::DIV_N_W-1:0] mag,
                                            input logic neg);
      logic [32:0] res;
      if (neg) begin
         if (mag > qrs_pkg::DIV_N_W'(33'h0_8000_0000)) begin
            res = {1'b1, 32'h8000_0000};
         end else begin
            res = {1'b0, 32'(-mag[31:0])};
         end
      end else begin
         if (mag > qrs_pkg::DIV_N_W'(32'h7FFF_FFFF)) begin
            res = {1'b1, 32'h7FFF_FFFF};
         end else begin
            res = {1'b0, mag[31:0]};
         end
      end
      return res;
   endfunction

   // Roots from the linear and the two-root cases snap to zero when they
   // fall within the coefficient tolerance; the single quadratic root does not.
   always_comb begin
      sat0      = sat_root(dv_q0, dv_side.neg0);
      sat1      = sat_root(dv_q1, dv_side.neg1);
      count_in  = qrs_pkg::COUNT_NONE;
      first_in  = '0;
      second_in = '0;
      ovf_in    = 1'b0;
      case (dv_side.kind)
         qrs_pkg::KIND_INF: begin
            count_in = qrs_pkg::COUNT_INF;
         end
         qrs_pkg::KIND_LIN: begin
            count_in = qrs_pkg::COUNT_ONE;
            first_in = qrs_pkg::near_zero(sat0[31:0], coef_tol_ff) ? 32'd0 : sat0[31:0];
            ovf_in   = sat0[32];
         end
         qrs_pkg::KIND_ONE: begin
            count_in = qrs_pkg::COUNT_ONE;
            first_in = sat0[31:0];
            ovf_in   = sat0[32];
         end
         qrs_pkg::KIND_TWO: begin
            count_in  = qrs_pkg::COUNT_TWO;
            first_in  = qrs_pkg::near_zero(sat0[31:0], coef_tol_ff) ? 32'd0 : sat0[31:0];
            second_in = qrs_pkg::near_zero(sat1[31:0], coef_tol_ff) ? 32'd0 : sat1[31:0];
            ovf_in    = sat0[32] | sat1[32];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         count_ff  <= count_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, ovf_ff, second_ff, first_ff, count_ff};

   // With no roots or infinitely many, both roots and the flag are zero.
   `QRS_ASSERT_IMPL(a_absent_roots_zero, clock, reset,
      rsp_valid_ff && (count_ff == qrs_pkg::COUNT_NONE || count_ff == qrs_pkg::COUNT_INF),
      first_ff == 32'd0 && second_ff == 32'd0 && !ovf_ff)

   // A single root leaves the second root at zero.
   `QRS_ASSERT_IMPL(a_single_root_second_zero, clock, reset,
      rsp_valid_ff && count_ff == qrs_pkg::COUNT_ONE, second_ff == 32'd0)

   // The overflow flag is only raised alongside a saturated root.
   `QRS_ASSERT_IMPL(a_overflow_saturated, clock, reset,
      rsp_valid_ff && ovf_ff,
      first_ff == 32'h7FFF_FFFF || first_ff == 32'h8000_0000 ||
      second_ff == 32'h7FFF_FFFF || second_ff == 32'h8000_0000)

   // A coefficient tolerance write lands in the register on the next cycle.
   `QRS_ASSERT_NEXT(a_coef_tol_write, clock, reset,
      csr_valid && csr_index == qrs_pkg::CSR_COEF_TOL,
      coef_tol_ff == $past(csr_data[15:0]))

endmodule
`default_nettype wire
